@@ hw/rtl/mandelbrot_escape_time_pixel_macros.svh @@
// Assertion helpers shared by the escape-time pixel block.
// All checks sample on the rising clock edge and are off while reset is held.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// Same-cycle implication.
`define MET_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/met_pkg.sv @@
`default_nettype none

package met_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int FRAC_BITS       = 28;
    localparam int COUNT_WIDTH     = 10;
    localparam int DIM_WIDTH       = 12;
    localparam int RW_WIDTH        = DIM_WIDTH + 1;
    localparam int GLYPH_WIDTH     = 7;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = (COORD_WIDTH > RW_WIDTH) ? COORD_WIDTH : RW_WIDTH;
    localparam int PROD_WIDTH      = 2 * COORD_WIDTH;
    // truncated square or cross term after the range check: at most 4.0
    localparam int SQ_WIDTH        = FRAC_BITS + 3;
    localparam int SUM_WIDTH       = SQ_WIDTH + 1;
    // exact sums before saturation
    localparam int WIDE_WIDTH      = COORD_WIDTH + DIM_WIDTH + 2;
    localparam int IN_TDATA_WIDTH  = ((2 * DIM_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH = ((COUNT_WIDTH + GLYPH_WIDTH + 7) / 8) * 8;

    localparam logic [COORD_WIDTH-1:0] MAG_TWO  = COORD_WIDTH'(64'd1 << (FRAC_BITS + 1));
    localparam logic [SUM_WIDTH-1:0]   SUM_FOUR = SUM_WIDTH'(64'd1 << (FRAC_BITS + 2));

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam logic signed [COORD_WIDTH-1:0] RST_ORIGIN_REAL = COORD_WIDTH'(-64'sd536870912);
    localparam logic signed [COORD_WIDTH-1:0] RST_ORIGIN_IMAG = COORD_WIDTH'(64'sd268435456);
    localparam logic signed [COORD_WIDTH-1:0] RST_STEP_REAL   = COORD_WIDTH'(64'sd8217412);
    localparam logic signed [COORD_WIDTH-1:0] RST_STEP_IMAG   = COORD_WIDTH'(-64'sd16777216);
    localparam logic [COUNT_WIDTH-1:0]        RST_MAX_ITER    = COUNT_WIDTH'(100);
    localparam logic [RW_WIDTH-1:0]           RST_ROW_WIDTH   = RW_WIDTH'(99);

    localparam logic [GLYPH_WIDTH-1:0] GLYPH_SPACE = 7'h20;
    localparam logic [GLYPH_WIDTH-1:0] GLYPH_HASH  = 7'h23;
    localparam int                     SHADE_COUNT = 10;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_ORIGIN_REAL = 3'd0,
        REG_ORIGIN_IMAG = 3'd1,
        REG_STEP_REAL   = 3'd2,
        REG_STEP_IMAG   = 3'd3,
        REG_MAX_ITER    = 3'd4,
        REG_ROW_WIDTH   = 3'd5
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMUL,
        ST_CADD,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin_real;
        logic signed [COORD_WIDTH-1:0] origin_imag;
        logic signed [COORD_WIDTH-1:0] step_real;
        logic signed [COORD_WIDTH-1:0] step_imag;
        logic [COUNT_WIDTH-1:0]        max_iter;
        logic [RW_WIDTH-1:0]           row_width;
    } t_cfg;

    // operand pairs for the three multipliers
    typedef struct packed {
        logic [COORD_WIDTH-1:0] a0;
        logic [COORD_WIDTH-1:0] b0;
        logic [COORD_WIDTH-1:0] a1;
        logic [COORD_WIDTH-1:0] b1;
        logic [COORD_WIDTH-1:0] a2;
        logic [COORD_WIDTH-1:0] b2;
    } t_mul_ops;

    function automatic logic [GLYPH_WIDTH-1:0] shade_glyph(input logic [3:0] idx);
        logic [GLYPH_WIDTH-1:0] g;
        case (idx)
            4'd0:    g = 7'h2e; // .
            4'd1:    g = 7'h27; // '
            4'd2:    g = 7'h2c; // ,
            4'd3:    g = 7'h3b; // ;
            4'd4:    g = 7'h22; // "
            4'd5:    g = 7'h6f; // o
            4'd6:    g = 7'h4f; // O
            4'd7:    g = 7'h25; // %
            4'd8:    g = 7'h38; // 8
            4'd9:    g = 7'h40; // @
            default: g = GLYPH_SPACE;
        endcase
        return g;
    endfunction

    function automatic logic signed [WIDE_WIDTH-1:0] sext_coord(
        input logic signed [COORD_WIDTH-1:0] v
    );
        return {{(WIDE_WIDTH-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
    endfunction

    // clamp an exact sum into the coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [WIDE_WIDTH-1:0] v
    );
        logic signed [COORD_WIDTH-1:0] r;
        if ((v[WIDE_WIDTH-1:COORD_WIDTH-1] == '0) || (v[WIDE_WIDTH-1:COORD_WIDTH-1] == '1)) begin
            r = v[COORD_WIDTH-1:0];
        end else if (v[WIDE_WIDTH-1]) begin
            r = COORD_MIN;
        end else begin
            r = COORD_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/met_cfg_regs.sv @@
`default_nettype none

module met_cfg_regs
    import met_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output t_cfg                            o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_real <= RST_ORIGIN_REAL;
            r_cfg.origin_imag <= RST_ORIGIN_IMAG;
            r_cfg.step_real   <= RST_STEP_REAL;
            r_cfg.step_imag   <= RST_STEP_IMAG;
            r_cfg.max_iter    <= RST_MAX_ITER;
            r_cfg.row_width   <= RST_ROW_WIDTH;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                REG_ORIGIN_REAL: r_cfg.origin_real <= i_cfg_data[COORD_WIDTH-1:0];
                REG_ORIGIN_IMAG: r_cfg.origin_imag <= i_cfg_data[COORD_WIDTH-1:0];
                REG_STEP_REAL:   r_cfg.step_real   <= i_cfg_data[COORD_WIDTH-1:0];
                REG_STEP_IMAG:   r_cfg.step_imag   <= i_cfg_data[COORD_WIDTH-1:0];
                REG_MAX_ITER:    r_cfg.max_iter    <= i_cfg_data[COUNT_WIDTH-1:0];
                REG_ROW_WIDTH:   r_cfg.row_width   <= i_cfg_data[RW_WIDTH-1:0];
                default: ; // unmapped index: dropped
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/met_mul_unit.sv @@
`default_nettype none

module met_mul_unit
    import met_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire t_mul_ops              i_ops,
    output logic [PROD_WIDTH-1:0]      o_p0,
    output logic [PROD_WIDTH-1:0]      o_p1,
    output logic [PROD_WIDTH-1:0]      o_p2
);

    logic [PROD_WIDTH-1:0] r_p0, r_p1, r_p2;

    // unsigned magnitude products, registered
    always_ff @(posedge i_clk) begin
        r_p0 <= PROD_WIDTH'(i_ops.a0) * PROD_WIDTH'(i_ops.b0);
        r_p1 <= PROD_WIDTH'(i_ops.a1) * PROD_WIDTH'(i_ops.b1);
        r_p2 <= PROD_WIDTH'(i_ops.a2) * PROD_WIDTH'(i_ops.b2);
    end

    assign o_p0 = r_p0;
    assign o_p1 = r_p1;
    assign o_p2 = r_p2;

endmodule

`default_nettype wire

@@ hw/rtl/mandelbrot_escape_time_pixel.sv @@
// Escape-time evaluator for one Mandelbrot pixel. Each transfer on s_axis carries a
// column and row; the block forms c = origin + col*step_real + i*(origin_imag +
// row*step_imag) in signed Q4.28 (saturated), then iterates z = z^2 + c from z = 0
// while |z|^2 <= 4, up to max_iterations steps. One result per pixel leaves on m_axis:
// the step count, an ASCII shade glyph, and tlast when col is the last column of the
// row (col + 1 == row_width). Work is one pixel at a time: s_axis_tready is high only
// while the sequencer is idle, and a finished result waits in the output register so
// the next pixel can be taken before it is drained. A pixel passes through coordinate
// setup (the coordinate products, then the sums) and then its counted steps; each step
// goes through the shared registered multiplier unit (three 32x32 products) and then
// the escape compare and saturating update. Registers must be written through the cfg
// channel only while no pixel is in flight; the block itself does not enforce this.
// The step registers are normally set by software to the corner span divided by
// (size - 1).
`default_nettype none
`include "mandelbrot_escape_time_pixel_macros.svh"

module mandelbrot_escape_time_pixel
    import met_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // pixel in
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,   // col, row
    // result out
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [OUT_TDATA_WIDTH-1:0]      m_axis_tdata,   // iteration_count, glyph, zero pad
    output logic                            m_axis_tlast,   // end_of_row
    // register writes
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    t_cfg                   w_cfg;
    t_mul_ops               w_ops;
    logic [PROD_WIDTH-1:0]  w_p0, w_p1, w_p2;

    t_state                 r_state, n_state;
    logic [DIM_WIDTH-1:0]   r_col, r_row;
    logic signed [COORD_WIDTH-1:0] r_cr, r_ci, r_zr, r_zi;
    logic signed [COORD_WIDTH-1:0] n_cr, n_ci, n_zr, n_zi;
    logic [COUNT_WIDTH-1:0] r_count;

    logic                   r_out_valid;
    logic [COUNT_WIDTH-1:0] r_out_count;
    logic [GLYPH_WIDTH-1:0] r_out_glyph, n_out_glyph;
    logic                   r_out_last, n_out_last;

    logic                   w_accept;
    logic                   w_load_out;
    logic                   w_at_limit;
    logic                   w_big;
    logic                   w_escape_sum;
    logic [COORD_WIDTH-1:0] w_zr_mag, w_zi_mag, w_step_r_mag, w_step_i_mag;
    logic [SQ_WIDTH-1:0]    w_sr, w_si, w_cross;
    logic [SUM_WIDTH-1:0]   w_sq_sum;

    met_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    met_mul_unit u_mul (
        .i_clk (i_clk),
        .i_ops (w_ops),
        .o_p0  (w_p0),
        .o_p1  (w_p1),
        .o_p2  (w_p2)
    );

    // ---------------- handshakes ----------------
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    // result register frees up on the same edge it is drained
    assign w_load_out    = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_WIDTH'({r_out_glyph, r_out_count});
    assign m_axis_tlast  = r_out_last;

    // ---------------- magnitudes and escape tests ----------------
    assign w_zr_mag     = r_zr[COORD_WIDTH-1] ? COORD_WIDTH'(-r_zr) : COORD_WIDTH'(r_zr);
    assign w_zi_mag     = r_zi[COORD_WIDTH-1] ? COORD_WIDTH'(-r_zi) : COORD_WIDTH'(r_zi);
    assign w_step_r_mag = w_cfg.step_real[COORD_WIDTH-1] ? COORD_WIDTH'(-w_cfg.step_real)
                                                         : COORD_WIDTH'(w_cfg.step_real);
    assign w_step_i_mag = w_cfg.step_imag[COORD_WIDTH-1] ? COORD_WIDTH'(-w_cfg.step_imag)
                                                         : COORD_WIDTH'(w_cfg.step_imag);

    assign w_at_limit = (r_count == w_cfg.max_iter);
    // either part beyond 2.0 escapes before squaring
    assign w_big      = (w_zr_mag > MAG_TWO) || (w_zi_mag > MAG_TWO);

    // products truncated toward zero to FRAC_BITS fraction bits
    assign w_sr         = w_p0[FRAC_BITS +: SQ_WIDTH];
    assign w_si         = w_p1[FRAC_BITS +: SQ_WIDTH];
    assign w_cross      = w_p2[FRAC_BITS +: SQ_WIDTH];
    assign w_sq_sum     = SUM_WIDTH'(w_sr) + SUM_WIDTH'(w_si);
    assign w_escape_sum = (w_sq_sum > SUM_FOUR);

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_CMUL;
            ST_CMUL: n_state = ST_CADD;
            ST_CADD: n_state = ST_MUL;
            ST_MUL: begin
                if (w_at_limit || w_big) n_state = ST_DONE;
                else                     n_state = ST_ADD;
            end
            ST_ADD: begin
                if (w_escape_sum) n_state = ST_DONE;
                else              n_state = ST_MUL;
            end
            ST_DONE: if (w_load_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: multiplier operands ----------------
    always_comb begin
        unique case (r_state)
            ST_CMUL: begin
                // |step| times the pixel index; sign is applied afterwards
                w_ops.a0 = w_step_r_mag;
                w_ops.b0 = COORD_WIDTH'(r_col);
                w_ops.a1 = w_step_i_mag;
                w_ops.b1 = COORD_WIDTH'(r_row);
                w_ops.a2 = '0;
                w_ops.b2 = '0;
            end
            default: begin
                // re^2, im^2, |re|*|im|
                w_ops.a0 = w_zr_mag;
                w_ops.b0 = w_zr_mag;
                w_ops.a1 = w_zi_mag;
                w_ops.b1 = w_zi_mag;
                w_ops.a2 = w_zr_mag;
                w_ops.b2 = w_zi_mag;
            end
        endcase
    end

    // ---------------- datapath ----------------
    always_comb begin
        logic signed [WIDE_WIDTH-1:0] term_r, term_i, cross2;
        term_r = WIDE_WIDTH'(w_p0[COORD_WIDTH+DIM_WIDTH-1:0]);
        term_i = WIDE_WIDTH'(w_p1[COORD_WIDTH+DIM_WIDTH-1:0]);
        if (w_cfg.step_real[COORD_WIDTH-1]) term_r = -term_r;
        if (w_cfg.step_imag[COORD_WIDTH-1]) term_i = -term_i;
        n_cr = sat_coord(sext_coord(w_cfg.origin_real) + term_r);
        n_ci = sat_coord(sext_coord(w_cfg.origin_imag) + term_i);

        // new z: re^2 - im^2 + c_re, +-2*|re|*|im| + c_im
        cross2 = WIDE_WIDTH'({w_cross, 1'b0});
        if (r_zr[COORD_WIDTH-1] != r_zi[COORD_WIDTH-1]) cross2 = -cross2;
        n_zr = sat_coord(WIDE_WIDTH'(w_sr) - WIDE_WIDTH'(w_si) + sext_coord(r_cr));
        n_zi = sat_coord(cross2 + sext_coord(r_ci));

        // glyph and end-of-row flag for the finished pixel
        if (w_at_limit || (r_count == '0)) begin
            n_out_glyph = GLYPH_SPACE;
        end else if (r_count > COUNT_WIDTH'(SHADE_COUNT)) begin
            n_out_glyph = GLYPH_HASH;
        end else begin
            n_out_glyph = shade_glyph(4'(r_count - COUNT_WIDTH'(1)));
        end
        n_out_last = ((RW_WIDTH'(r_col) + RW_WIDTH'(1)) == w_cfg.row_width);
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out)         r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_col <= s_axis_tdata[DIM_WIDTH-1:0];
            r_row <= s_axis_tdata[2*DIM_WIDTH-1:DIM_WIDTH];
        end
        if (r_state == ST_CADD) begin
            r_cr    <= n_cr;
            r_ci    <= n_ci;
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
        end
        if ((r_state == ST_ADD) && !w_escape_sum) begin
            r_zr    <= n_zr;
            r_zi    <= n_zi;
            r_count <= r_count + COUNT_WIDTH'(1);
        end
        if (w_load_out) begin
            r_out_count <= r_count;
            r_out_glyph <= n_out_glyph;
            r_out_last  <= n_out_last;
        end
    end

    // ---------------- assertions ----------------
    `MET_ASSERT_NEXT(a_accept_starts, w_accept, r_state == ST_CMUL, "pixel transfer did not start coordinate setup")
    `MET_ASSERT_IMPL(a_add_after_mul, r_state == ST_ADD, $past(r_state) == ST_MUL, "update step without products")
    `MET_ASSERT_NEXT(a_count_step, (r_state == ST_ADD) && !w_escape_sum, r_count == $past(r_count) + COUNT_WIDTH'(1), "step count did not advance by one")
    `MET_ASSERT_IMPL(a_zero_blank, r_out_valid && (r_out_count == '0), r_out_glyph == GLYPH_SPACE, "zero count must give a blank glyph")

endmodule

`default_nettype wire
